### sv/fheap_pkg.sv
// Shared constants for the five-ary min-heap: field widths, opcodes, status codes.
// No dependencies.
`timescale 1ns / 1ps

package fheap_pkg;

  localparam int KEY_W = 16;
  localparam int CNT_W = 9;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_DEL_MIN = 2'd1;
  localparam logic [1:0] OP_DEL_MAX = 2'd2;
  localparam logic [1:0] OP_REMOVE  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

endpackage

### sv/fheap_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fheap_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/five_ary_min_heap_top.sv
// Top level of the d-ary min-heap: sequencer, entry count and result register.
// Depends on fheap_pkg and fheap_ram.
`timescale 1ns / 1ps

// A d-ary min-heap of 16-bit unsigned keys in one RAM of CAPACITY entries.
// Each input beat (opcode in in_tuser, key in in_tdata) produces one result
// beat. One item is worked at a time; in_tready is high only while idle.
// All work goes through the single RAM read port, whose read data is registered:
// insert sifts up one tree level at a time; delete minimum sifts down one level
// at a time, reading up to ARITY children per level; delete maximum first scans
// all entries; remove scans from index 0 again after every copy taken. The
// result stays on out_* until out_tready. No clearing pass follows reset.
module five_ary_min_heap_top #(
  parameter int CAPACITY = 256,
  parameter int ARITY    = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [fheap_pkg::KEY_W-1:0]    in_tdata,   // [15:0] key
  input  logic [1:0]                     in_tuser,   // [1:0] opcode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] taken_key, [24:16] removed_count, [33:25] size, [34] empty_res
  output logic [39:0]                    out_tdata,
  output logic [1:0]                     out_tuser   // [1:0] status
);
  import fheap_pkg::*;

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(ARITY + 1);
  localparam int FW  = AW + $clog2(ARITY) + 1;
  localparam int PS  = AW + $clog2(ARITY) + 1;
  localparam int PM  = ((1 << PS) + ARITY - 1) / ARITY;
  localparam int PMW = $clog2(PM + 1);
  localparam int PW  = AW + PMW;

  typedef enum logic [3:0] {
    S_IDLE, S_RESP, S_DM_RD, S_DM_CAP, S_TK_RD, S_TK_WT,
    S_SU_RD, S_SU_CMP, S_SD_RD, S_SD_CMP, S_SD_END, S_SCAN
  } state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [AW-1:0]       at_r, at_nxt;
  logic [KEY_W-1:0]    cur_r, cur_nxt;
  logic [KEY_W-1:0]    best_key_r, best_key_nxt;
  logic [AW-1:0]       best_idx_r, best_idx_nxt;
  logic [CW-1:0]       c_r, c_nxt;
  logic                then_down_r, then_down_nxt;
  logic [CNT_W-1:0]    scan_i_r, scan_i_nxt;
  logic                rd_valid_r, rd_valid_nxt;
  logic [AW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [KEY_W-1:0]    taken_r, taken_nxt;
  logic [CNT_W-1:0]    removed_r, removed_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [KEY_W-1:0]    ram_wdata, ram_rdata;

  logic [PW-1:0]       par_prod;
  logic [AW-1:0]       parent;
  logic [FW-1:0]       child;
  logic [CNT_W-1:0]    cnt_dec;

  fheap_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign par_prod = PW'(pos_r - AW'(1)) * PW'(PM);
  assign parent   = AW'(par_prod >> PS);
  assign child    = FW'(pos_r) * FW'(ARITY) + FW'(1) + FW'(c_r);
  assign cnt_dec  = count_r - CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    at_nxt        = at_r;
    cur_nxt       = cur_r;
    best_key_nxt  = best_key_r;
    best_idx_nxt  = best_idx_r;
    c_nxt         = c_r;
    then_down_nxt = then_down_r;
    scan_i_nxt    = scan_i_r;
    rd_valid_nxt  = rd_valid_r;
    rd_idx_nxt    = rd_idx_r;
    status_nxt    = status_r;
    taken_nxt     = taken_r;
    removed_nxt   = removed_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = cur_r;
    ram_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt      = in_tuser;
          key_nxt     = in_tdata;
          taken_nxt   = '0;
          removed_nxt = '0;
          status_nxt  = ST_OK;
          scan_i_nxt  = '0;
          rd_valid_nxt = 1'b0;
          case (in_tuser)
            OP_INSERT: begin
              if (count_r >= CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                pos_nxt       = AW'(count_r);
                cur_nxt       = in_tdata;
                count_nxt     = count_r + CNT_W'(1);
                then_down_nxt = 1'b0;
                state_nxt     = S_SU_RD;
              end
            end
            OP_DEL_MIN: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_DM_RD;
              end
            end
            OP_DEL_MAX: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_SCAN;
            end
          endcase
        end
      end

      S_RESP: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end

      S_DM_RD: begin
        ram_raddr = '0;
        state_nxt = S_DM_CAP;
      end

      S_DM_CAP: begin
        taken_nxt = ram_rdata;
        at_nxt    = '0;
        state_nxt = S_TK_RD;
      end

      S_TK_RD: begin
        ram_raddr = AW'(cnt_dec);
        state_nxt = S_TK_WT;
      end

      S_TK_WT: begin
        cur_nxt   = ram_rdata;
        count_nxt = cnt_dec;
        if (CNT_W'(at_r) < cnt_dec) begin
          pos_nxt       = at_r;
          then_down_nxt = 1'b1;
          state_nxt     = S_SU_RD;
        end else if (op_r == OP_REMOVE) begin
          scan_i_nxt   = '0;
          rd_valid_nxt = 1'b0;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_SU_RD: begin
        ram_raddr = parent;
        if (pos_r == '0) begin
          if (then_down_r) begin
            best_key_nxt = cur_r;
            best_idx_nxt = pos_r;
            c_nxt        = '0;
            state_nxt    = S_SD_RD;
          end else begin
            ram_we    = 1'b1;
            state_nxt = S_RESP;
          end
        end else begin
          state_nxt = S_SU_CMP;
        end
      end

      S_SU_CMP: begin
        if (ram_rdata > cur_r) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_nxt   = parent;
          state_nxt = S_SU_RD;
        end else if (then_down_r) begin
          best_key_nxt = cur_r;
          best_idx_nxt = pos_r;
          c_nxt        = '0;
          state_nxt    = S_SD_RD;
        end else begin
          ram_we    = 1'b1;
          state_nxt = S_RESP;
        end
      end

      S_SD_RD: begin
        ram_raddr = AW'(child);
        if (c_r < CW'(ARITY) && child < FW'(count_r)) begin
          state_nxt = S_SD_CMP;
        end else begin
          state_nxt = S_SD_END;
        end
      end

      S_SD_CMP: begin
        if (ram_rdata < best_key_r) begin
          best_key_nxt = ram_rdata;
          best_idx_nxt = AW'(child);
        end
        c_nxt     = c_r + CW'(1);
        state_nxt = S_SD_RD;
      end

      S_SD_END: begin
        ram_we = 1'b1;
        if (best_idx_r == pos_r) begin
          if (op_r == OP_REMOVE) begin
            scan_i_nxt   = '0;
            rd_valid_nxt = 1'b0;
            state_nxt    = S_SCAN;
          end else begin
            state_nxt = S_RESP;
          end
        end else begin
          ram_wdata    = best_key_r;
          pos_nxt      = best_idx_r;
          best_key_nxt = cur_r;
          c_nxt        = '0;
          state_nxt    = S_SD_RD;
        end
      end

      S_SCAN: begin
        ram_raddr = AW'(scan_i_r);
        if (scan_i_r < count_r) begin
          scan_i_nxt   = scan_i_r + CNT_W'(1);
          rd_valid_nxt = 1'b1;
          rd_idx_nxt   = AW'(scan_i_r);
        end else begin
          rd_valid_nxt = 1'b0;
        end
        if (rd_valid_r) begin
          if (op_r == OP_REMOVE) begin
            if (ram_rdata == key_r) begin
              at_nxt      = rd_idx_r;
              removed_nxt = removed_r + CNT_W'(1);
              state_nxt   = S_TK_RD;
            end
          end else if (rd_idx_r == '0 || ram_rdata > best_key_r) begin
            best_key_nxt = ram_rdata;
            at_nxt       = rd_idx_r;
          end
        end else if (scan_i_r >= count_r) begin
          if (op_r == OP_REMOVE) begin
            status_nxt = (removed_r == '0) ? ST_NOT_FOUND : ST_OK;
            state_nxt  = S_RESP;
          end else begin
            taken_nxt = best_key_r;
            state_nxt = S_TK_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      rd_valid_r <= rd_valid_nxt;
    end
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    pos_r       <= pos_nxt;
    at_r        <= at_nxt;
    cur_r       <= cur_nxt;
    best_key_r  <= best_key_nxt;
    best_idx_r  <= best_idx_nxt;
    c_r         <= c_nxt;
    then_down_r <= then_down_nxt;
    scan_i_r    <= scan_i_nxt;
    rd_idx_r    <= rd_idx_nxt;
    status_r    <= status_nxt;
    taken_r     <= taken_nxt;
    removed_r   <= removed_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_RESP);
  assign out_tuser  = status_r;
  assign out_tdata  = {5'd0, (count_r == '0), count_r, removed_r, taken_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while result pending");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && status_r == ST_EMPTY) |-> (count_r == '0))
    else $error("empty status with entries present");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && status_r == ST_FULL) |-> (count_r == CNT_W'(CAPACITY)))
    else $error("full status below capacity");

endmodule
